### hw/rtl/output_sense_debounce_confirm_unit_macros.svh
// Assertion macros for the sense debounce and confirm RTL
`ifndef OUTPUT_SENSE_DEBOUNCE_CONFIRM_UNIT_MACROS_SVH
`define OUTPUT_SENSE_DEBOUNCE_CONFIRM_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset
`define OSDC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset
`define OSDC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/osdc_pkg.sv
// Package with payload types, the line map and shared constants
`default_nettype none

package osdc_pkg;

  // Largest supported line count, the line index width and the other field widths
  localparam int LINE_MAX = 16;
  localparam int LINE_W   = 4;
  localparam int CHAN_W   = 4;
  localparam int TIME_W   = 32;
  localparam int DEB_W    = 16;
  localparam int PORT_W   = 8;

  localparam logic [DEB_W-1:0] DEBOUNCE_RESET = 16'd50;

  // One input transaction
  typedef struct packed {
    logic [PORT_W-1:0] port_low;
    logic [PORT_W-1:0] port_high;
    logic [TIME_W-1:0] now_ms;
  } in_t;

  // One result transaction
  typedef struct packed {
    logic              is_event;
    logic [LINE_W-1:0] line;
    logic [CHAN_W-1:0] channel;
    logic              dummy;
    logic              settled;
    logic              last;
  } out_t;

  // Classified sample passed from front to back
  typedef struct packed {
    logic [LINE_MAX-1:0] fire;
    logic                settled;
  } job_t;

  // Line map entry: output channel and dummy mark
  typedef struct packed {
    logic [CHAN_W-1:0] chan;
    logic              dummy;
  } map_entry_t;

  localparam map_entry_t LINE_MAP [LINE_MAX] = '{
    '{4'd8, 1'b0}, '{4'd4, 1'b0}, '{4'd8, 1'b1}, '{4'd4, 1'b1},
    '{4'd7, 1'b0}, '{4'd3, 1'b0}, '{4'd7, 1'b1}, '{4'd3, 1'b1},
    '{4'd6, 1'b0}, '{4'd2, 1'b0}, '{4'd6, 1'b1}, '{4'd2, 1'b1},
    '{4'd5, 1'b0}, '{4'd1, 1'b0}, '{4'd5, 1'b1}, '{4'd1, 1'b1}
  };

endpackage

`default_nettype wire

### hw/rtl/osdc_front.sv
// Front end: debounce all lines of a sample and classify the rising edges
`default_nettype none

module osdc_front
  import osdc_pkg::*;
#(
  parameter int LINE_COUNT = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [DEB_W-1:0] cfg_wdata,
  input  wire logic             accept,
  input  wire in_t              sample,
  output      job_t             job
);

  logic [DEB_W-1:0]      debounce_r;
  logic [LINE_COUNT-1:0] stable_r, stable_nxt;
  logic [LINE_COUNT-1:0] pend_r, pend_nxt;
  logic [LINE_COUNT-1:0] prev_r, prev_nxt;
  logic [LINE_COUNT-1:0] fired_r, fired_nxt;
  logic [LINE_COUNT-1:0] open_win;
  logic [LINE_COUNT-1:0] fire;
  logic [TIME_W-1:0]     time_r [LINE_COUNT];
  logic [2*PORT_W-1:0]   ports;

  assign ports = {sample.port_high, sample.port_low};

  // Per-line debounce and edge classification, all lines side by side
  always_comb begin
    logic             level;
    logic             diff;
    logic             expired;
    logic [TIME_W-1:0] elapsed;
    for (int i = 0; i < LINE_COUNT; i++) begin
      level   = ~ports[i];
      diff    = level != stable_r[i];
      elapsed = sample.now_ms - time_r[i];
      expired = elapsed >= {{(TIME_W-DEB_W){1'b0}}, debounce_r};
      open_win[i]   = diff && !pend_r[i];
      stable_nxt[i] = (diff && pend_r[i] && expired) ? level : stable_r[i];
      pend_nxt[i]   = diff && !(pend_r[i] && expired);
      fire[i]       = stable_nxt[i] && !prev_r[i] && !fired_r[i];
      if (stable_nxt[i] && !prev_r[i]) begin
        fired_nxt[i] = 1'b1;
      end else if (!stable_nxt[i] && prev_r[i]) begin
        fired_nxt[i] = 1'b0;
      end else begin
        fired_nxt[i] = fired_r[i];
      end
      prev_nxt[i] = stable_nxt[i];
    end
  end

  assign job.fire    = LINE_MAX'(fire);
  assign job.settled = ~|pend_nxt;

  // Hold the debounce interval
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= DEBOUNCE_RESET;
    end else if (cfg_we) begin
      debounce_r <= cfg_wdata;
    end
  end

  // Advance line state on each accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stable_r <= '0;
      pend_r   <= '0;
      prev_r   <= '0;
      fired_r  <= '0;
    end else if (accept) begin
      stable_r <= stable_nxt;
      pend_r   <= pend_nxt;
      prev_r   <= prev_nxt;
      fired_r  <= fired_nxt;
    end
  end

  // Stamp the window opening time
  always_ff @(posedge clk) begin
    for (int i = 0; i < LINE_COUNT; i++) begin
      if (accept && open_win[i]) begin
        time_r[i] <= sample.now_ms;
      end
    end
  end

endmodule

`default_nettype wire

### hw/rtl/osdc_queue.sv
// Two-entry queue of classified samples between front and back
`default_nettype none

module osdc_queue
  import osdc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire job_t push_data,
  output      logic full,
  input  wire logic pop,
  output      logic valid,
  output      job_t head
);

  localparam int DEPTH = 2;

  job_t                       mem_r [DEPTH];
  logic [$clog2(DEPTH)-1:0]   wr_ptr_r, rd_ptr_r;
  logic [$clog2(DEPTH+1)-1:0] count_r;
  logic                       do_push, do_pop;

  assign full    = count_r == ($clog2(DEPTH+1))'(DEPTH);
  assign valid   = count_r != '0;
  assign head    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

`default_nettype wire

### hw/rtl/osdc_back.sv
// Back end: walk a sample's fire mask and emit events, then the status
`default_nettype none

`include "output_sense_debounce_confirm_unit_macros.svh"

module osdc_back
  import osdc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic q_valid,
  input  wire job_t q_head,
  output      logic q_pop,
  output      logic out_empty,
  input  wire logic out_pop,
  output      out_t out_data
);

  logic                cur_valid_r, cur_valid_nxt;
  logic [LINE_MAX-1:0] cur_mask_r, cur_mask_nxt;
  logic                cur_settled_r, cur_settled_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_t                out_r, out_nxt;
  logic                slot_free, emit, has_ev, finish, load;
  logic [LINE_W-1:0]   idx;

  assign slot_free = !out_valid_r || out_pop;
  assign emit      = cur_valid_r && slot_free;
  assign has_ev    = |cur_mask_r;
  assign finish    = emit && !has_ev;
  assign load      = !cur_valid_r || finish;
  assign q_pop     = load && q_valid;

  // Pick the lowest pending line
  always_comb begin
    idx = '0;
    for (int i = LINE_MAX - 1; i >= 0; i--) begin
      if (cur_mask_r[i]) begin
        idx = LINE_W'(i);
      end
    end
  end

  // Load the next sample or retire one line of the current one
  always_comb begin
    cur_valid_nxt   = cur_valid_r;
    cur_mask_nxt    = cur_mask_r;
    cur_settled_nxt = cur_settled_r;
    if (load) begin
      cur_valid_nxt   = q_valid;
      cur_mask_nxt    = q_head.fire;
      cur_settled_nxt = q_head.settled;
    end else if (emit) begin
      cur_mask_nxt = cur_mask_r & (cur_mask_r - 1'b1);
    end
  end

  // Build the next result transaction
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      if (has_ev) begin
        out_nxt.is_event = 1'b1;
        out_nxt.line     = idx;
        out_nxt.channel  = LINE_MAP[idx].chan;
        out_nxt.dummy    = LINE_MAP[idx].dummy;
        out_nxt.settled  = 1'b0;
        out_nxt.last     = 1'b0;
      end else begin
        out_nxt.is_event = 1'b0;
        out_nxt.line     = '0;
        out_nxt.channel  = '0;
        out_nxt.dummy    = 1'b0;
        out_nxt.settled  = cur_settled_r;
        out_nxt.last     = 1'b1;
      end
    end else if (out_pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold payload
  always_ff @(posedge clk) begin
    cur_mask_r    <= cur_mask_nxt;
    cur_settled_r <= cur_settled_nxt;
    out_r         <= out_nxt;
  end

  assign out_empty = !out_valid_r;
  assign out_data  = out_r;

  `OSDC_ASSERT_IMP(a_event_fields, out_valid_r && out_r.is_event, !out_r.last && !out_r.settled && out_r.channel != '0, "event result carries bad fields")
  `OSDC_ASSERT_IMP(a_status_fields, out_valid_r && !out_r.is_event, out_r.last && out_r.channel == '0 && out_r.line == '0, "status result carries bad fields")
  `OSDC_ASSERT_NXT(a_line_order, out_valid_r && out_pop && out_r.is_event, !out_valid_r || !out_r.is_event || out_r.line > $past(out_r.line), "events out of line order")

endmodule

`default_nettype wire

### hw/rtl/output_sense_debounce_confirm_unit.sv
// Top level of the sense line debounce and confirm unit
`default_nettype none

// Takes one sample of the two active-low sense ports plus a millisecond
// timestamp per input transaction, debounces every line against the
// programmed interval and returns one confirm event per newly stable high
// line, in line order, followed by one status result (last = 1). The front
// end debounces all lines of a sample side by side and takes a new
// sample every cycle while its two-entry queue has room; the back end emits
// one result per cycle while its output slot is free, so a sample yields
// 1 + (number of events) results, between 1 and LINE_COUNT + 1. cfg_wdata
// loads the debounce interval in milliseconds (reset value 50) and is to be
// written only while no sample is in flight.
module output_sense_debounce_confirm_unit
  import osdc_pkg::*;
#(
  parameter int LINE_COUNT = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [DEB_W-1:0] cfg_wdata,
  input  wire logic             in_push,
  output      logic             in_full,
  input  wire in_t              in_data,
  output      logic             out_empty,
  input  wire logic             out_pop,
  output      out_t             out_data
);

  logic accept;
  job_t job;
  logic q_full, q_valid, q_pop;
  job_t q_head;

  assign in_full = q_full;
  assign accept  = in_push && !q_full;

  osdc_front #(
    .LINE_COUNT (LINE_COUNT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .sample    (in_data),
    .job       (job)
  );

  osdc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (job),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  osdc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

### dv/tb_output_sense_debounce_confirm_unit.sv
// Self-checking testbench for the sense line debounce and confirm unit
`default_nettype none

module tb_output_sense_debounce_confirm_unit;
  import osdc_pkg::*;

  localparam int NUM_LINES    = 16;
  localparam int IDLE_PCT     = 27;
  localparam int SETTLE_PAD   = 8;
  localparam int STALL_LIMIT  = 4000;
  localparam int RANDOM_ITEMS = 80;

  // Channel and dummy mark per sense line
  localparam logic [CHAN_W-1:0] CHAN_OF [NUM_LINES] = '{
    4'd8, 4'd4, 4'd8, 4'd4, 4'd7, 4'd3, 4'd7, 4'd3,
    4'd6, 4'd2, 4'd6, 4'd2, 4'd5, 4'd1, 4'd5, 4'd1
  };
  localparam logic [NUM_LINES-1:0] DUMMY_LINES = 16'hCCCC;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [DEB_W-1:0] cfg_wdata;
  logic             in_push;
  logic             in_full;
  in_t              in_data;
  logic             out_empty;
  logic             out_pop;
  out_t             out_data;

  output_sense_debounce_confirm_unit u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_data  (in_data),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_data (out_data)
  );

  // Pending samples and expected results
  in_t  sample_q[$];
  out_t confirm_q[$];

  // Predicted debounce state per line
  logic [DEB_W-1:0]     interval_ms;
  logic [NUM_LINES-1:0] stable_lvl;
  logic [NUM_LINES-1:0] pend;
  logic [TIME_W-1:0]    pend_since [NUM_LINES];
  logic [NUM_LINES-1:0] prev_stable;
  logic [NUM_LINES-1:0] fired;

  bit   steady;
  int   err_count;
  int   n_samples;
  int   n_events;
  int   n_status;
  int   n_cfg;
  int   stall_cycles;

  // Stimulus generator state
  logic [TIME_W-1:0]    clock_ms;
  logic [2*PORT_W-1:0]  held_ports;

  always #5 clk = ~clk;

  // Debounce one accepted sample and queue the results it causes
  function automatic void debounce_sample(in_t s);
    logic [2*PORT_W-1:0] raw;
    logic                lvl;
    logic [TIME_W-1:0]   age;
    logic                any_pend;
    out_t                r;
    raw      = {s.port_high, s.port_low};
    any_pend = 1'b0;
    for (int i = 0; i < NUM_LINES; i++) begin
      lvl = ~raw[i];
      if (lvl != stable_lvl[i]) begin
        if (!pend[i]) begin
          pend[i]       = 1'b1;
          pend_since[i] = s.now_ms;
        end else begin
          age = s.now_ms - pend_since[i];
          if (age >= TIME_W'(interval_ms)) begin
            stable_lvl[i] = lvl;
            pend[i]       = 1'b0;
          end
        end
      end else begin
        pend[i] = 1'b0;
      end
      if (stable_lvl[i] && !prev_stable[i]) begin
        if (!fired[i]) begin
          fired[i]   = 1'b1;
          r          = '0;
          r.is_event = 1'b1;
          r.line     = LINE_W'(i);
          r.channel  = CHAN_OF[i];
          r.dummy    = DUMMY_LINES[i];
          confirm_q.push_back(r);
          n_events++;
        end
      end else if (!stable_lvl[i] && prev_stable[i]) begin
        fired[i] = 1'b0;
      end
      prev_stable[i] = stable_lvl[i];
      any_pend       = any_pend | pend[i];
    end
    r         = '0;
    r.settled = ~any_pend;
    r.last    = 1'b1;
    confirm_q.push_back(r);
    n_status++;
  endfunction

  // Driver: hold a transaction until accepted, then feed the next one
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else begin
      if (in_push && !in_full) begin
        debounce_sample(in_data);
        n_samples++;
      end
      if (!(in_push && in_full)) begin
        if (sample_q.size() > 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
          in_data <= sample_q.pop_front();
          in_push <= 1'b1;
        end else begin
          in_push <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each popped result against the oldest expectation
  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        if (confirm_q.size() == 0) begin
          $display("%0t unexpected result: ev=%0b line=%0d ch=%0d dm=%0b st=%0b last=%0b",
                   $time, out_data.is_event, out_data.line, out_data.channel,
                   out_data.dummy, out_data.settled, out_data.last);
          err_count++;
        end else begin
          want = confirm_q.pop_front();
          if (out_data.is_event !== want.is_event || out_data.line !== want.line ||
              out_data.channel !== want.channel || out_data.dummy !== want.dummy ||
              out_data.settled !== want.settled || out_data.last !== want.last) begin
            $display("%0t mismatch: expected ev=%0b line=%0d ch=%0d dm=%0b st=%0b last=%0b",
                     $time, want.is_event, want.line, want.channel, want.dummy,
                     want.settled, want.last);
            $display("%0t            actual ev=%0b line=%0d ch=%0d dm=%0b st=%0b last=%0b",
                     $time, out_data.is_event, out_data.line, out_data.channel,
                     out_data.dummy, out_data.settled, out_data.last);
            err_count++;
          end
        end
      end
      out_pop <= steady || $urandom_range(99) >= IDLE_PCT;
    end
  end

  // Watchdog: end the run when no transaction moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty) || cfg_we) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t watchdog: no transaction for %0d cycles, %0d results outstanding",
               $time, STALL_LIMIT, confirm_q.size());
      $display("** output_sense_debounce_confirm_unit: FAILED **");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic queue_sample(logic [PORT_W-1:0] lo, logic [PORT_W-1:0] hi,
                              logic [TIME_W-1:0] t);
    in_t s;
    s.port_low  = lo;
    s.port_high = hi;
    s.now_ms    = t;
    sample_q.push_back(s);
  endtask

  // Wait until every sample is in and every result is out
  task automatic wait_drained();
    while (sample_q.size() > 0 || in_push || confirm_q.size() > 0)
      @(posedge clk);
    repeat (SETTLE_PAD) @(posedge clk);
  endtask

  // Load a new debounce interval while the unit is idle
  task automatic set_interval(logic [DEB_W-1:0] v);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we      <= 1'b0;
    interval_ms = v;
    n_cfg++;
  endtask

  // Random samples: mostly held patterns with advancing time, plus glitches
  task automatic random_samples(int count);
    int unsigned          pick;
    int unsigned          span;
    logic [2*PORT_W-1:0]  sent;
    clock_ms   = $urandom;
    held_ports = 16'($urandom);
    span       = interval_ms;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(99);
      sent = held_ports;
      if (pick < 55) begin
        sent = held_ports;
      end else if (pick < 75) begin
        held_ports = held_ports ^ 16'($urandom & $urandom & $urandom);
        sent       = held_ports;
      end else if (pick < 88) begin
        sent = held_ports ^ 16'($urandom & $urandom);
      end else begin
        sent = 16'($urandom);
        if ($urandom_range(1)) held_ports = sent;
      end
      pick = $urandom_range(99);
      if (pick < 80)
        clock_ms = clock_ms + $urandom_range(span / 2 + 1, 0);
      else if (pick < 95)
        clock_ms = clock_ms + $urandom_range(2 * span + 3, span);
      else
        clock_ms = $urandom;
      queue_sample(sent[PORT_W-1:0], sent[2*PORT_W-1:PORT_W], clock_ms);
    end
  endtask

  initial begin
    clk         = 1'b0;
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_wdata   = '0;
    in_push     = 1'b0;
    in_data     = '0;
    out_pop     = 1'b0;
    interval_ms = DEBOUNCE_RESET;
    stable_lvl  = '0;
    pend        = '0;
    prev_stable = '0;
    fired       = '0;
    steady      = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset interval, timestamp zero and wrap, all lines at once
    queue_sample(8'hFF, 8'hFF, 32'h0000_0000);
    queue_sample(8'h00, 8'h00, 32'hFFFF_FFFF);
    queue_sample(8'h00, 8'h00, 32'h0000_0010);
    queue_sample(8'h00, 8'h00, 32'h0000_0031);
    queue_sample(8'h00, 8'h00, 32'h0000_0040);
    queue_sample(8'hFF, 8'hFF, 32'h0000_0050);
    queue_sample(8'hFF, 8'hFF, 32'h0000_0090);
    // Open a window, cancel it, reopen and accept
    queue_sample(8'hAA, 8'h55, 32'h0000_0100);
    queue_sample(8'hFF, 8'hFF, 32'h0000_0200);
    queue_sample(8'hAA, 8'h55, 32'h0000_0210);
    queue_sample(8'hAA, 8'h55, 32'h0000_0250);

    // Directed: zero interval accepts on the second differing sample in a row
    set_interval(16'd0);
    queue_sample(8'h55, 8'hAA, 32'h0000_0000);
    queue_sample(8'h55, 8'hAA, 32'h0000_0000);
    queue_sample(8'hFF, 8'hFF, 32'h7FFF_FFFF);
    queue_sample(8'hFF, 8'hFF, 32'h8000_0000);
    queue_sample(8'h00, 8'h00, 32'hFFFF_FFFF);
    queue_sample(8'h00, 8'h00, 32'hFFFF_FFFF);

    // Directed: longest interval across the timestamp wrap
    set_interval(16'hFFFF);
    queue_sample(8'hFF, 8'hFF, 32'hFFFF_8000);
    queue_sample(8'hFF, 8'hFF, 32'h0000_7FFE);
    queue_sample(8'hFF, 8'hFF, 32'h0000_7FFF);
    queue_sample(8'h00, 8'h00, 32'h0001_0000);

    // Random phases over several intervals, last one without idling
    random_samples(RANDOM_ITEMS);
    set_interval(16'd0);
    random_samples(RANDOM_ITEMS);
    set_interval(16'd1);
    random_samples(RANDOM_ITEMS);
    set_interval(16'($urandom_range(65535)));
    random_samples(RANDOM_ITEMS);
    set_interval(DEBOUNCE_RESET);
    wait_drained();
    steady = 1'b1;
    random_samples(RANDOM_ITEMS);
    wait_drained();
    steady = 1'b0;
    repeat (20) @(posedge clk);

    $display("Covered %0d samples, %0d confirm events, %0d status results",
             n_samples, n_events, n_status);
    $display("across %0d interval writes including 0 and 65535, with %0d errors",
             n_cfg, err_count);
    if (err_count == 0 && confirm_q.size() == 0) begin
      $display("** output_sense_debounce_confirm_unit: PASSED **");
    end else begin
      $display("** output_sense_debounce_confirm_unit: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
